// ===== rtl/filtered_motion_rep_counter_macros.svh =====
`ifndef FILTERED_MOTION_REP_COUNTER_MACROS_SVH
`define FILTERED_MOTION_REP_COUNTER_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger
`define FMRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define FMRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fmrc_pkg.sv =====
`default_nettype none
package fmrc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 32;
  localparam int LOCK_W   = 16;
  localparam int REG_IDX_W = 3;

  // Register indexes of the configuration port
  localparam logic [REG_IDX_W-1:0] REG_STAND   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DOWN    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOTTOM  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RISE    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOCKOUT = 3'd4;

  // Register reset values
  localparam logic signed [SAMPLE_W-1:0] STAND_RST   = 16'sd15000;
  localparam logic signed [SAMPLE_W-1:0] DOWN_RST    = 16'sd13800;
  localparam logic signed [SAMPLE_W-1:0] BOTTOM_RST  = 16'sd12800;
  localparam logic signed [SAMPLE_W-1:0] RISE_RST    = 16'sd13800;
  localparam logic [LOCK_W-1:0]          LOCKOUT_RST = 16'd1200;

  typedef enum logic [1:0] {
    PH_STAND  = 2'd0,
    PH_DOWN   = 2'd1,
    PH_BOTTOM = 2'd2,
    PH_UP     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIVIDE,
    ST_OUTPUT
  } ctrl_state_t;

endpackage
`default_nettype wire

// ===== rtl/fmrc_cell.sv =====
`default_nettype none
module fmrc_cell
  import fmrc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       shift,
  input  wire logic signed [SAMPLE_W-1:0] din,
  output logic signed [SAMPLE_W-1:0]      dout
);

  logic signed [SAMPLE_W-1:0] held;

  // Take the neighbor's word on each accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (shift) begin
      held <= din;
    end
  end

  assign dout = held;

endmodule
`default_nettype wire

// ===== rtl/fmrc_div.sv =====
`default_nettype none
module fmrc_div #(
  parameter int DW = 20,
  parameter int VW = 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [DW-1:0] dividend,
  input  wire logic [VW-1:0]        divisor,
  output logic                      done,
  output logic signed [DW-1:0]      quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic          fix;
  logic [CW-1:0] step;
  logic          neg;
  logic [DW-1:0] quo;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;

  // One restoring step: shift in the next dividend bit and try a subtract
  assign trial = {rem, quo[DW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == CW'(DW - 1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: magnitude divide, then restore the sign
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DW-1];
      quo <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DW-2:0], fits};
      rem <= fits ? diff[VW-1:0] : trial[VW-1:0];
    end else if (fix) begin
      quotient <= neg ? -$signed(quo) : $signed(quo);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/filtered_motion_rep_counter.sv =====
// Each input word is accepted only in the idle state; the running sum, SUM_W = 17 + clog2(WINDOW_LEN)
// bits wide, is then divided by the fill count in a bit-serial divider, and the result word is
// loaded into the output register; no new word is taken (in_stall high) until that load, so a
// result word still waiting in the output holds off the next one.
// Reset (rst, synchronous, active high) clears the window cells, sum, fill count, phase,
// repetition count and last repetition time, and loads the default thresholds.
`default_nettype none
`include "filtered_motion_rep_counter_macros.svh"
module filtered_motion_rep_counter
  import fmrc_pkg::*;
#(
  parameter int WINDOW_LEN = 5
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [REG_IDX_W-1:0]       cfg_index,
  input  wire logic [SAMPLE_W-1:0]        cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic [TIME_W-1:0]          time_ms,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [SAMPLE_W-1:0]      average,
  output logic [1:0]                      phase,
  output logic [COUNT_W-1:0]              rep_total,
  output logic                            rep_counted
);

  localparam int SUM_W = 17 + $clog2(WINDOW_LEN);
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);

  // Configuration registers
  logic signed [SAMPLE_W-1:0] stand_level;
  logic signed [SAMPLE_W-1:0] down_level;
  logic signed [SAMPLE_W-1:0] bottom_level;
  logic signed [SAMPLE_W-1:0] rise_level;
  logic [LOCK_W-1:0]          lockout_ms;

  ctrl_state_t state, state_next;

  logic                       accept;
  logic                       div_start;
  logic                       div_done;
  logic                       load_out;
  logic signed [SUM_W-1:0]    quotient;
  logic signed [SAMPLE_W-1:0] tap [WINDOW_LEN+1];
  logic signed [SUM_W-1:0]    window_sum;
  logic signed [SUM_W-1:0]    window_sum_next;
  logic [CNT_W-1:0]           fill;
  logic [CNT_W-1:0]           fill_next;
  logic [TIME_W-1:0]          time_q;
  logic signed [SAMPLE_W-1:0] avg_q;
  phase_t                     motion_phase;
  phase_t                     motion_phase_next;
  logic [COUNT_W-1:0]         rep_counter;
  logic [TIME_W-1:0]          last_rep_ms;
  logic [TIME_W-1:0]          gap;
  logic                       counted;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stand_level  <= STAND_RST;
      down_level   <= DOWN_RST;
      bottom_level <= BOTTOM_RST;
      rise_level   <= RISE_RST;
      lockout_ms   <= LOCKOUT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STAND:   stand_level  <= cfg_data;
        REG_DOWN:    down_level   <= cfg_data;
        REG_BOTTOM:  bottom_level <= cfg_data;
        REG_RISE:    rise_level   <= cfg_data;
        REG_LOCKOUT: lockout_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window: a row of cells, newest sample enters at the head, oldest leaves at the tail
  assign tap[0] = sample;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    fmrc_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (accept),
      .din   (tap[i]),
      .dout  (tap[i+1])
    );
  end

  // Running sum and fill count
  assign window_sum_next = window_sum + SUM_W'(sample) - SUM_W'(tap[WINDOW_LEN]);
  assign fill_next = (fill == CNT_W'(WINDOW_LEN)) ? fill : fill + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
      fill       <= '0;
    end else if (accept) begin
      window_sum <= window_sum_next;
      fill       <= fill_next;
    end
  end

  // Hold the timestamp of the word at work
  always_ff @(posedge clk) begin
    if (accept) begin
      time_q <= time_ms;
    end
  end

  fmrc_div #(
    .DW (SUM_W),
    .VW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (window_sum),
    .divisor  (fill),
    .done     (div_done),
    .quotient (quotient)
  );

  // Capture the average
  always_ff @(posedge clk) begin
    if (div_done) begin
      avg_q <= quotient[SAMPLE_W-1:0];
    end
  end

  // Control sequence: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_START;
      ST_START:  state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_done) state_next = ST_OUTPUT;
      ST_OUTPUT: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control sequence: outputs
  always_comb begin
    in_stall  = (state != ST_IDLE);
    div_start = (state == ST_START);
    load_out  = (state == ST_OUTPUT) && (!out_valid || !out_stall);
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Motion phase machine: next phase
  assign gap = time_q - last_rep_ms;

  always_comb begin
    motion_phase_next = motion_phase;
    case (motion_phase)
      PH_STAND: begin
        if (avg_q < down_level) motion_phase_next = PH_DOWN;
      end
      PH_DOWN: begin
        if (avg_q < bottom_level) begin
          motion_phase_next = PH_BOTTOM;
        end else if (avg_q > stand_level) begin
          motion_phase_next = PH_STAND;
        end
      end
      PH_BOTTOM: begin
        if (avg_q > rise_level) motion_phase_next = PH_UP;
      end
      PH_UP: begin
        if (avg_q > stand_level) motion_phase_next = PH_STAND;
      end
      default: motion_phase_next = PH_STAND;
    endcase
  end

  // Motion phase machine: count a rise back to standing once the lockout has passed
  always_comb begin
    counted = (motion_phase == PH_UP) && (avg_q > stand_level) && (gap > TIME_W'(lockout_ms));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_phase <= PH_STAND;
      rep_counter  <= '0;
      last_rep_ms  <= '0;
    end else if (load_out) begin
      motion_phase <= motion_phase_next;
      if (counted) begin
        rep_counter <= rep_counter + 1'b1;
        last_rep_ms <= time_q;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      average     <= avg_q;
      phase       <= motion_phase_next;
      rep_total   <= counted ? rep_counter + 1'b1 : rep_counter;
      rep_counted <= counted;
    end
  end

  // Checks
  `FMRC_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= CNT_W'(WINDOW_LEN), "fill count above window length")
  `FMRC_ASSERT_NOW(a_count_at_stand, clk, rst, out_valid && rep_counted, phase == PH_STAND, "repetition counted outside standing")
  `FMRC_ASSERT_NEXT(a_count_step, clk, rst, load_out && counted, rep_counter == $past(rep_counter) + 1'b1, "repetition count did not advance by one")

endmodule
`default_nettype wire

// ===== bench/tb_filtered_motion_rep_counter.sv =====
`timescale 1ns / 1ps

module tb_filtered_motion_rep_counter
  import fmrc_pkg::*;
();

  localparam int WIN_LEN = 5;
  localparam int SETTLE  = 40;
  localparam int LIMIT   = 600000;

  // indexes past the last register, writes to them must do nothing
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_A = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_B = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_C = 3'd7;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] avg;
    phase_t                     ph;
    logic [COUNT_W-1:0]         total;
    logic                       counted;
  } rep_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic [TIME_W-1:0]          stamp;
    logic                       typed;
    rep_word_t                  want;
  } drill_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [REG_IDX_W-1:0]       cfg_index = '0;
  logic [SAMPLE_W-1:0]        cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic [TIME_W-1:0]          time_ms = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] average;
  logic [1:0]                 phase;
  logic [COUNT_W-1:0]         rep_total;
  logic                       rep_counted;

  // predictor copy of the block state and registers
  logic signed [SAMPLE_W-1:0] win_cells [WIN_LEN];
  int                         win_sum = 0;
  int                         win_slot = 0;
  bit                         win_full = 1'b0;
  phase_t                     motion = PH_STAND;
  logic [COUNT_W-1:0]         reps = '0;
  logic [TIME_W-1:0]          last_rep_stamp = '0;
  logic signed [SAMPLE_W-1:0] lvl_stand = STAND_RST;
  logic signed [SAMPLE_W-1:0] lvl_down = DOWN_RST;
  logic signed [SAMPLE_W-1:0] lvl_bottom = BOTTOM_RST;
  logic signed [SAMPLE_W-1:0] lvl_rise = RISE_RST;
  logic [LOCK_W-1:0]          lock_gap = LOCKOUT_RST;

  rep_word_t  pending [$];
  drill_row_t drill [$];
  rep_word_t  blank = '0;
  int         errors = 0;
  int         words_sent = 0;
  int         cycles = 0;
  int         gap_pct = 0;
  int         stall_pct = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  filtered_motion_rep_counter #(
    .WINDOW_LEN(WIN_LEN)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .time_ms(time_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .average(average),
    .phase(phase),
    .rep_total(rep_total),
    .rep_counted(rep_counted)
  );

  always #4 clk = ~clk;

  // Advance the window average and the motion phase by one sample
  function automatic rep_word_t advance_counter(input logic signed [SAMPLE_W-1:0] s,
                                                input logic [TIME_W-1:0] now);
    rep_word_t r;
    int divisor;
    int mean;
    r = '0;
    win_sum = win_sum - win_cells[win_slot] + s;
    win_cells[win_slot] = s;
    win_slot++;
    if (win_slot >= WIN_LEN) begin
      win_slot = 0;
      win_full = 1'b1;
    end
    divisor = win_full ? WIN_LEN : win_slot;
    mean = win_sum / divisor;
    case (motion)
      PH_STAND: begin
        if (mean < lvl_down) motion = PH_DOWN;
      end
      PH_DOWN: begin
        if (mean < lvl_bottom) motion = PH_BOTTOM;
        else if (mean > lvl_stand) motion = PH_STAND;
      end
      PH_BOTTOM: begin
        if (mean > lvl_rise) motion = PH_UP;
      end
      default: begin
        if (mean > lvl_stand) begin
          // count only once the lockout has strictly passed, with wrap
          if (TIME_W'(now - last_rep_stamp) > lock_gap) begin
            reps = reps + 1'b1;
            last_rep_stamp = now;
            r.counted = 1'b1;
          end
          motion = PH_STAND;
        end
      end
    endcase
    r.avg = SAMPLE_W'(mean);
    r.ph = motion;
    r.total = reps;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clip16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return SAMPLE_W'(v);
  endfunction

  // Step the stroke clock, with a rare jump anywhere in the 32-bit range
  function automatic logic [TIME_W-1:0] next_stamp();
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(10, 500);
    return clock_ms;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    errors++;
  endtask

  // Offer one word, hold it until taken, then queue its expected result
  task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t,
                           input logic typed, input rep_word_t want);
    rep_word_t model_res;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    time_ms <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_res = advance_counter(s, t);
    if (typed) pending.push_back(want);
    else pending.push_back(model_res);
    words_sent++;
  endtask

  // Drop valid and wait until every result is back and the pipe is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_STAND:   lvl_stand = val;
      REG_DOWN:    lvl_down = val;
      REG_BOTTOM:  lvl_bottom = val;
      REG_RISE:    lvl_rise = val;
      REG_LOCKOUT: lock_gap = val;
      default: ;
    endcase
  endtask

  task automatic load_levels(input logic [SAMPLE_W-1:0] stand, input logic [SAMPLE_W-1:0] down,
                             input logic [SAMPLE_W-1:0] bottom, input logic [SAMPLE_W-1:0] rise,
                             input logic [SAMPLE_W-1:0] lockout);
    write_reg(REG_STAND, stand);
    write_reg(REG_DOWN, down);
    write_reg(REG_BOTTOM, bottom);
    write_reg(REG_RISE, rise);
    write_reg(REG_LOCKOUT, lockout);
  endtask

  // Mostly down/up strokes around the current levels, with some raw noise
  task automatic run_strokes(input int count);
    int stop_at;
    int lo_i;
    int hi_i;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 9) < 2) begin
        repeat ($urandom_range(1, 4)) send_word(SAMPLE_W'($urandom), next_stamp(), 1'b0, blank);
      end else begin
        lo_i = (lvl_bottom < lvl_down ? lvl_bottom : lvl_down) - int'($urandom_range(1, 4000));
        hi_i = (lvl_stand > lvl_rise ? lvl_stand : lvl_rise) + int'($urandom_range(1, 4000));
        repeat ($urandom_range(1, 7))
          send_word(clip16(lo_i + int'($urandom_range(0, 600)) - 300), next_stamp(), 1'b0, blank);
        repeat ($urandom_range(1, 7))
          send_word(clip16(hi_i + int'($urandom_range(0, 600)) - 300), next_stamp(), 1'b0, blank);
      end
    end
  endtask

  // Receiver stall bursts
  initial begin
    forever begin
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Compare each taken result word with the oldest expectation
  always @(posedge clk) begin : check_results
    rep_word_t head;
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        flag_mismatch("result word with nothing expected");
      end else begin
        head = pending.pop_front();
        if (average !== head.avg)
          flag_mismatch($sformatf("average %0d, want %0d", average, head.avg));
        if (phase !== head.ph)
          flag_mismatch($sformatf("phase %0d, want %0d", phase, head.ph));
        if (rep_total !== head.total)
          flag_mismatch($sformatf("rep_total %0d, want %0d", rep_total, head.total));
        if (rep_counted !== head.counted)
          flag_mismatch($sformatf("rep_counted %0b, want %0b", rep_counted, head.counted));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("** filtered_motion_rep_counter: FAILED **");
      $finish;
    end
  end

  initial begin
    foreach (win_cells[i]) win_cells[i] = '0;

    // fill phase, abort, bottom, lockout return, count across the timestamp wrap
    drill.push_back('{16'sd0, 32'd0, 1'b1, '{16'sd0, PH_DOWN, 32'd0, 1'b0}});
    drill.push_back('{16'sh7FFF, 32'd10, 1'b1, '{16'sd16383, PH_STAND, 32'd0, 1'b0}});
    drill.push_back('{16'sh8000, 32'd20, 1'b1, '{16'sd0, PH_DOWN, 32'd0, 1'b0}});
    drill.push_back('{16'sh8000, 32'd30, 1'b1, '{-16'sd8192, PH_BOTTOM, 32'd0, 1'b0}});
    drill.push_back('{16'sh7FFF, 32'd40, 1'b1, '{16'sd0, PH_BOTTOM, 32'd0, 1'b0}});
    drill.push_back('{16'sh7FFF, 32'd100, 1'b0, '0});
    drill.push_back('{16'sh7FFF, 32'd200, 1'b0, '0});
    drill.push_back('{16'sh7FFF, 32'd300, 1'b0, '0});
    drill.push_back('{16'sh7FFF, 32'd400, 1'b0, '0});
    drill.push_back('{16'sh7FFF, 32'd1200, 1'b0, '0});
    drill.push_back('{16'sh8000, 32'd1300, 1'b0, '0});
    drill.push_back('{16'sh8000, 32'd1400, 1'b0, '0});
    drill.push_back('{16'sh8000, 32'd1500, 1'b0, '0});
    drill.push_back('{16'sh7FFF, 32'd1600, 1'b0, '0});
    drill.push_back('{16'sh7FFF, 32'd1700, 1'b0, '0});
    drill.push_back('{16'sh7FFF, 32'd1800, 1'b0, '0});
    drill.push_back('{16'sh7FFF, 32'd1900, 1'b0, '0});
    drill.push_back('{16'sh7FFF, 32'hFFFF_FF00, 1'b0, '0});
    drill.push_back('{16'sh8000, 32'hFFFF_FF40, 1'b0, '0});
    drill.push_back('{16'sh8000, 32'hFFFF_FF80, 1'b0, '0});
    drill.push_back('{16'sh8000, 32'hFFFF_FFC0, 1'b0, '0});
    drill.push_back('{16'sh7FFF, 32'hFFFF_FFFF, 1'b0, '0});
    drill.push_back('{16'sh7FFF, 32'h0000_0100, 1'b0, '0});
    drill.push_back('{16'sh7FFF, 32'h0000_0200, 1'b0, '0});
    drill.push_back('{16'sh7FFF, 32'h0000_0300, 1'b0, '0});
    drill.push_back('{16'sh7FFF, 32'h0000_0400, 1'b0, '0});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk at reset levels
    gap_pct = 15;
    stall_pct = 15;
    foreach (drill[i]) send_word(drill[i].smp, drill[i].stamp, drill[i].typed, drill[i].want);
    drain();

    // reset levels written back, spare indexes poked with junk
    load_levels(16'd15000, 16'd13800, 16'd12800, 16'd13800, 16'd1200);
    write_reg(REG_UNUSED_A, 16'h1234);
    write_reg(REG_UNUSED_B, 16'hFFFF);
    write_reg(REG_UNUSED_C, 16'h0000);
    gap_pct = 20;
    stall_pct = 20;
    run_strokes(200);
    drain();

    // extremes: nothing can go below the floor, lockout at its maximum
    load_levels(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF);
    gap_pct = 30;
    stall_pct = 30;
    run_strokes(200);
    drain();

    // thresholds reversed, no lockout: the phase spins and counts often
    load_levels(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000);
    gap_pct = 0;
    stall_pct = 30;
    run_strokes(200);
    drain();

    // ordered random levels, stroke clock started just short of the wrap
    begin : ordered_levels
      int base_lvl;
      int down_off;
      base_lvl = int'($urandom_range(0, 40000)) - 20000;
      down_off = $urandom_range(0, 2000);
      load_levels(SAMPLE_W'(base_lvl + down_off + int'($urandom_range(500, 5000))),
                  SAMPLE_W'(base_lvl + down_off), SAMPLE_W'(base_lvl),
                  SAMPLE_W'(base_lvl + int'($urandom_range(0, 2000))),
                  SAMPLE_W'($urandom_range(0, 3000)));
    end
    clock_ms = 32'hFFFF_F000;
    gap_pct = 10;
    stall_pct = 0;
    run_strokes(200);
    drain();

    // fully random register values
    load_levels(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    gap_pct = 30;
    stall_pct = 30;
    run_strokes(200);
    drain();

    // closing stretch at full rate
    load_levels(16'd15000, 16'd13800, 16'd12800, 16'd13800, SAMPLE_W'($urandom_range(0, 800)));
    gap_pct = 0;
    stall_pct = 0;
    run_strokes(200);
    drain();

    if (errors == 0) begin
      $display("** filtered_motion_rep_counter: PASSED **");
    end else begin
      $display("** filtered_motion_rep_counter: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fmrc_pkg.sv
rtl/fmrc_cell.sv
rtl/fmrc_div.sv
rtl/filtered_motion_rep_counter.sv
bench/tb_filtered_motion_rep_counter.sv
